@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/esq_pkg.sv @@
// types and constants for the expiring session tx queue
package esq_pkg;

	localparam int REF_W = 32;
	localparam int LEN_W = 11;
	localparam int TIME_W = 48;
	localparam int TTL_W = 24;
	localparam int MS_W = 8;
	localparam int DELAY_W = 9;
	localparam int EPOCH_W = 32;
	localparam int CTR_W = 32;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [TTL_W-1:0] TTL_RST = 24'd400000;
	localparam logic [LEN_W-1:0] MAX_LEN_RST = 11'd1536;
	localparam logic [MS_W-1:0] RETRY_INIT_RST = 8'd2;
	localparam logic [MS_W-1:0] RETRY_CAP_RST = 8'd32;
	localparam logic [EPOCH_W-1:0] EPOCH_RST = 32'd1;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_OFFER = 2'd1,
		OP_SET_ENABLE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_QUEUED = 3'd0,
		ST_NOT_READY = 3'd1,
		ST_BAD_LEN = 3'd2,
		ST_FULL = 3'd3,
		ST_EMPTY = 3'd4,
		ST_SENT = 3'd5,
		ST_EXPIRED = 3'd6,
		ST_BUSY = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_TTL = 2'd0,
		REG_MAX_LEN = 2'd1,
		REG_RETRY_INIT = 2'd2,
		REG_RETRY_CAP = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TTL_W-1:0] ttl;
		logic [LEN_W-1:0] max_len;
		logic [MS_W-1:0] retry_init;
		logic [MS_W-1:0] retry_cap;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic [REF_W-1:0] frame_ref;
		logic [LEN_W-1:0] frame_length;
		logic [TIME_W-1:0] now_us;
		logic host_mounted;
		logic endpoint_ready;
		logic enable;
	} item_t;

	typedef struct packed {
		logic [REF_W-1:0] frame_ref;
		logic [LEN_W-1:0] frame_length;
		logic [TIME_W-1:0] stamp;
		logic [EPOCH_W-1:0] epoch;
	} slot_t;

endpackage

@@ hdl/esq_regs.sv @@
// apb configuration registers
module esq_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [esq_pkg::ADDR_W-1:0] paddr,
	input logic [esq_pkg::DATA_W-1:0] pwdata,
	output logic [esq_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output esq_pkg::cfg_t cfg
);

	esq_pkg::cfg_t cfg_q;
	esq_pkg::reg_idx_t sel;
	logic wr_go;

	assign pready = 1'b1;
	assign sel = esq_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_go = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ttl <= esq_pkg::TTL_RST;
			cfg_q.max_len <= esq_pkg::MAX_LEN_RST;
			cfg_q.retry_init <= esq_pkg::RETRY_INIT_RST;
			cfg_q.retry_cap <= esq_pkg::RETRY_CAP_RST;
		end else if (wr_go) begin
			case (sel)
				esq_pkg::REG_TTL: cfg_q.ttl <= pwdata[esq_pkg::TTL_W-1:0];
				esq_pkg::REG_MAX_LEN: cfg_q.max_len <= pwdata[esq_pkg::LEN_W-1:0];
				esq_pkg::REG_RETRY_INIT: cfg_q.retry_init <= pwdata[esq_pkg::MS_W-1:0];
				esq_pkg::REG_RETRY_CAP: cfg_q.retry_cap <= pwdata[esq_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			esq_pkg::REG_TTL: prdata = esq_pkg::DATA_W'(cfg_q.ttl);
			esq_pkg::REG_MAX_LEN: prdata = esq_pkg::DATA_W'(cfg_q.max_len);
			esq_pkg::REG_RETRY_INIT: prdata = esq_pkg::DATA_W'(cfg_q.retry_init);
			esq_pkg::REG_RETRY_CAP: prdata = esq_pkg::DATA_W'(cfg_q.retry_cap);
			default: prdata = '0;
		endcase
	end

endmodule

@@ hdl/esq_ring.sv @@
// descriptor ring storage with registered head read
module esq_ring #(
	parameter int DEPTH = 64,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input logic clk,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_idx,
	input esq_pkg::slot_t wr_data,
	input logic [IDX_W-1:0] rd_idx,
	output esq_pkg::slot_t head
);

	esq_pkg::slot_t mem [DEPTH];
	esq_pkg::slot_t head_q;

	assign head = head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		// forward a word written to the slot about to become head
		if (wr_en && (wr_idx == rd_idx)) begin
			head_q <= wr_data;
		end else begin
			head_q <= mem[rd_idx];
		end
	end

endmodule

@@ hdl/esq_ctrl.sv @@
// queue state, counters and result register
module esq_ctrl #(
	parameter int DEPTH = 64,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic vld_s1,
	input esq_pkg::item_t item_s1,
	input esq_pkg::cfg_t cfg,
	input esq_pkg::slot_t head,
	output logic wr_en,
	output logic [IDX_W-1:0] wr_idx,
	output esq_pkg::slot_t wr_data,
	output logic [IDX_W-1:0] rd_idx_next,
	output logic done,
	output logic [2:0] status,
	output logic [esq_pkg::REF_W-1:0] sent_ref,
	output logic [esq_pkg::LEN_W-1:0] sent_length,
	output logic [esq_pkg::DELAY_W-1:0] retry_delay_ms,
	output logic [CNT_W-1:0] pending_count,
	output logic [esq_pkg::CTR_W-1:0] sent_count,
	output logic [esq_pkg::CTR_W-1:0] busy_count,
	output logic [esq_pkg::CTR_W-1:0] expired_count,
	output logic [esq_pkg::CTR_W-1:0] drop_count,
	output logic is_enabled
);

	logic [IDX_W-1:0] rd_q, wr_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [esq_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
	logic [esq_pkg::DELAY_W-1:0] delay_q, delay_d;
	logic [esq_pkg::CTR_W-1:0] sent_q, busy_q, exp_q, drop_q;
	logic sent_inc, busy_inc, exp_inc, drop_inc;

	logic done_s2;
	esq_pkg::status_t status_s2, status_d;
	logic [esq_pkg::REF_W-1:0] ref_s2, ref_d;
	logic [esq_pkg::LEN_W-1:0] len_s2, len_d;
	logic [esq_pkg::DELAY_W-1:0] dly_s2, dly_d;

	logic enabled, empty, full, expired, wr_go, rd_go;
	logic [esq_pkg::TIME_W-1:0] age;

	always_comb begin
		enabled = ~epoch_q[0];
		empty = (count_q == '0);
		full = (count_q == CNT_W'(DEPTH));
		age = item_s1.now_us - head.stamp;
		expired = !enabled || (head.epoch != epoch_q) ||
			(age >= esq_pkg::TIME_W'(cfg.ttl)) || !item_s1.host_mounted;

		wr_go = 1'b0;
		rd_go = 1'b0;
		sent_inc = 1'b0;
		busy_inc = 1'b0;
		exp_inc = 1'b0;
		drop_inc = 1'b0;
		status_d = esq_pkg::ST_QUEUED;
		ref_d = '0;
		len_d = '0;
		dly_d = '0;
		epoch_d = epoch_q;
		delay_d = delay_q;

		if (vld_s1) begin
			case (esq_pkg::op_t'(item_s1.op))
				esq_pkg::OP_ENQUEUE: begin
					if (!enabled || !item_s1.host_mounted) begin
						status_d = esq_pkg::ST_NOT_READY;
					end else if ((item_s1.frame_length == '0) ||
						(item_s1.frame_length > cfg.max_len)) begin
						status_d = esq_pkg::ST_BAD_LEN;
					end else if (full) begin
						drop_inc = 1'b1;
						status_d = esq_pkg::ST_FULL;
					end else begin
						wr_go = 1'b1;
					end
				end
				esq_pkg::OP_OFFER: begin
					if (empty) begin
						delay_d = {1'b0, cfg.retry_init};
						status_d = esq_pkg::ST_EMPTY;
					end else if (expired) begin
						exp_inc = 1'b1;
						rd_go = 1'b1;
						status_d = esq_pkg::ST_EXPIRED;
					end else if (item_s1.endpoint_ready) begin
						sent_inc = 1'b1;
						rd_go = 1'b1;
						ref_d = head.frame_ref;
						len_d = head.frame_length;
						status_d = esq_pkg::ST_SENT;
					end else begin
						busy_inc = 1'b1;
						dly_d = delay_q;
						if (delay_q < {1'b0, cfg.retry_cap}) begin
							delay_d = {delay_q[esq_pkg::DELAY_W-2:0], 1'b0};
						end
						status_d = esq_pkg::ST_BUSY;
					end
				end
				esq_pkg::OP_SET_ENABLE: begin
					if (item_s1.enable != enabled) begin
						epoch_d = epoch_q + 1'b1;
					end
				end
				default: ;
			endcase
		end

		if (wr_go) begin
			count_d = count_q + 1'b1;
		end else if (rd_go) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end

		if (!rd_go) begin
			rd_idx_next = rd_q;
		end else if (rd_q == IDX_W'(DEPTH - 1)) begin
			rd_idx_next = '0;
		end else begin
			rd_idx_next = rd_q + 1'b1;
		end
	end

	assign wr_en = wr_go;
	assign wr_idx = wr_q;
	assign wr_data = '{frame_ref: item_s1.frame_ref, frame_length: item_s1.frame_length,
		stamp: item_s1.now_us, epoch: epoch_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
			epoch_q <= esq_pkg::EPOCH_RST;
			delay_q <= {1'b0, esq_pkg::RETRY_INIT_RST};
			sent_q <= '0;
			busy_q <= '0;
			exp_q <= '0;
			drop_q <= '0;
			done_s2 <= 1'b0;
		end else begin
			rd_q <= rd_idx_next;
			if (wr_go) begin
				wr_q <= (wr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			count_q <= count_d;
			epoch_q <= epoch_d;
			delay_q <= delay_d;
			sent_q <= sent_q + esq_pkg::CTR_W'(sent_inc);
			busy_q <= busy_q + esq_pkg::CTR_W'(busy_inc);
			exp_q <= exp_q + esq_pkg::CTR_W'(exp_inc);
			drop_q <= drop_q + esq_pkg::CTR_W'(drop_inc);
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_s2 <= status_d;
			ref_s2 <= ref_d;
			len_s2 <= len_d;
			dly_s2 <= dly_d;
		end
	end

	assign done = done_s2;
	assign status = status_s2;
	assign sent_ref = ref_s2;
	assign sent_length = len_s2;
	assign retry_delay_ms = dly_s2;
	assign pending_count = count_q;
	assign sent_count = sent_q;
	assign busy_count = busy_q;
	assign expired_count = exp_q;
	assign drop_count = drop_q;
	assign is_enabled = ~epoch_q[0];

endmodule

@@ hdl/expiring_session_tx_queue.sv @@
// top level of the expiring session tx queue
//
// a command word (enqueue, offer head, set enabled) is taken at a rising edge
// with start high and busy low; busy stays low, so a word may be issued every
// cycle. each word gives exactly one result word on the result ports, marked
// by done for one cycle; the receiver cannot hold it off.
// a word taken is held in the input register, handled from there by the control
// block, and its result is shown with done high from the result register.
// throughput: one word per cycle, set by the head descriptor register, which
// is reloaded from the ring read port every cycle with write forwarding.
// the counters, pending count and enabled flag on the result ports show the
// state after the word marked by done.
// configuration goes through the apb port while the queue is idle; pready is
// always high and reads return the register values.
// reset: ring empty, session disabled, counters zero, registers at defaults,
// retry delay at the default initial value; ring contents are not cleared.
`include "assert_macros.svh"

module expiring_session_tx_queue #(
	parameter int DEPTH = 64,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [esq_pkg::REF_W-1:0] frame_ref,
	input logic [esq_pkg::LEN_W-1:0] frame_length,
	input logic [esq_pkg::TIME_W-1:0] now_us,
	input logic host_mounted,
	input logic endpoint_ready,
	input logic enable,
	output logic done,
	output logic [2:0] status,
	output logic [esq_pkg::REF_W-1:0] sent_ref,
	output logic [esq_pkg::LEN_W-1:0] sent_length,
	output logic [esq_pkg::DELAY_W-1:0] retry_delay_ms,
	output logic [CNT_W-1:0] pending_count,
	output logic [esq_pkg::CTR_W-1:0] sent_count,
	output logic [esq_pkg::CTR_W-1:0] busy_count,
	output logic [esq_pkg::CTR_W-1:0] expired_count,
	output logic [esq_pkg::CTR_W-1:0] drop_count,
	output logic is_enabled,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [esq_pkg::ADDR_W-1:0] paddr,
	input logic [esq_pkg::DATA_W-1:0] pwdata,
	output logic [esq_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	esq_pkg::cfg_t cfg;
	esq_pkg::item_t item_s1;
	esq_pkg::slot_t head, wr_data;
	logic vld_s1, wr_en, accept;
	logic [IDX_W-1:0] wr_idx, rd_idx_next;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{op: operation, frame_ref: frame_ref, frame_length: frame_length,
				now_us: now_us, host_mounted: host_mounted,
				endpoint_ready: endpoint_ready, enable: enable};
		end
	end

	esq_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	esq_ring #(.DEPTH(DEPTH)) u_ring (
		.clk(clk),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.rd_idx(rd_idx_next),
		.head(head)
	);

	esq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s1(vld_s1),
		.item_s1(item_s1),
		.cfg(cfg),
		.head(head),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.rd_idx_next(rd_idx_next),
		.done(done),
		.status(status),
		.sent_ref(sent_ref),
		.sent_length(sent_length),
		.retry_delay_ms(retry_delay_ms),
		.pending_count(pending_count),
		.sent_count(sent_count),
		.busy_count(busy_count),
		.expired_count(expired_count),
		.drop_count(drop_count),
		.is_enabled(is_enabled)
	);

	`ASSERT_NEXT(a_word_gives_result, clk, arst_n, vld_s1, done, "missing result word")
	`ASSERT_IMPLY(a_pending_bound, clk, arst_n, done, pending_count <= CNT_W'(DEPTH), "pending above depth")
	`ASSERT_IMPLY(a_full_means_full, clk, arst_n, done && (status == esq_pkg::ST_FULL), pending_count == CNT_W'(DEPTH), "full status with room")
	`ASSERT_IMPLY(a_sent_counts, clk, arst_n, done && (status == esq_pkg::ST_SENT), sent_count == ($past(sent_count) + 1'b1), "sent count not bumped")
	`ASSERT_IMPLY(a_unsent_zero, clk, arst_n, done && (status != esq_pkg::ST_SENT), (sent_ref == '0) && (sent_length == '0), "sent fields set without send")

endmodule
